FILE: src/gtls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtls_pkg
// Shared types, widths and command/status words for the giant tour splitter.
// ----------------------------------------------------------------------------
package gtls_pkg;

    // longest tour handled; position counts run 0..MAX_TOUR
    localparam int MAX_TOUR = 64;
    localparam int POS_W    = $clog2(MAX_TOUR + 1);
    localparam int QADDR_W  = $clog2(MAX_TOUR);

    // field widths fixed by the interface
    localparam int ID_W    = 16;
    localparam int DEM_W   = 16;
    localparam int DST_W   = 24;
    localparam int CFG_W   = 24;
    localparam int RN_W    = 6;
    localparam int FP_W    = 7;
    localparam int COST_W  = 48;

    // internal arithmetic widths
    localparam int LOAD_W  = DEM_W + POS_W;
    localparam int DIST_W  = DST_W + POS_W;
    localparam int CVAL_W  = COST_W + 3;
    localparam int SUM_W   = CVAL_W + 1;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  customer_id;
        logic [DEM_W-1:0] demand;
        logic [DST_W-1:0] dist_from_prev;
        logic [DST_W-1:0] dist_from_depot;
        logic [DST_W-1:0] dist_to_depot;
        logic             last_customer;
    } t_in_word;

    typedef struct packed {
        logic              feasible;
        logic [RN_W-1:0]   route_number;
        logic [FP_W-1:0]   first_position;
        logic [FP_W-1:0]   last_position;
        logic [COST_W-1:0] split_cost;
        logic              last_route;
    } t_out_word;

    // deque entry: candidate index, its prefix load and its potential
    typedef struct packed {
        logic [POS_W-1:0]         idx;
        logic [LOAD_W-1:0]        load;
        logic signed [CVAL_W-1:0] val;
    } t_qent;

    // route stack entry built while walking predecessors
    typedef struct packed {
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
    } t_stk;

    typedef struct packed {
        logic accept;
        logic q_rd_back;
        logic tail_dec;
        logic push;
        logic head_inc;
        logic set_infeas;
        logic commit;
        logic walk_init;
        logic walk_step;
        logic out_init;
        logic load_inf;
        logic load_out;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic infeas;
        logic q_ne;
        logic back_pop;
        logic front_pop;
        logic tour_end;
        logic walk_done;
        logic out_last;
    } t_stat;

endpackage

FILE: src/gtls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtls_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gtls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtls_ctrl
// Sequencer: deque update per customer, predecessor walk and route output.
// ----------------------------------------------------------------------------
module gtls_ctrl
    import gtls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BACK_RD,
        S_BACK_CMP,
        S_PUSH,
        S_FRONT_RD,
        S_FRONT_CMP,
        S_END,
        S_INF_LD,
        S_WALK_RD,
        S_WALK_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_BACK_RD;
                end
            end
            S_BACK_RD: begin
                if (i_stat.infeas) begin
                    n_state = S_END;
                end else if (i_stat.q_ne) begin
                    o_cmd.q_rd_back = 1'b1;
                    n_state         = S_BACK_CMP;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_BACK_CMP: begin
                if (i_stat.back_pop) begin
                    o_cmd.tail_dec = 1'b1;
                    n_state        = S_BACK_RD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FRONT_RD;
            end
            S_FRONT_RD: begin
                if (i_stat.q_ne) begin
                    n_state = S_FRONT_CMP;
                end else begin
                    o_cmd.set_infeas = 1'b1;
                    n_state          = S_END;
                end
            end
            S_FRONT_CMP: begin
                if (i_stat.front_pop) begin
                    o_cmd.head_inc = 1'b1;
                    n_state        = S_FRONT_RD;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_END;
                end
            end
            S_END: begin
                if (!i_stat.tour_end) begin
                    n_state = S_IDLE;
                end else if (i_stat.infeas) begin
                    n_state = S_INF_LD;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end
            end
            S_INF_LD: begin
                o_cmd.load_inf = 1'b1;
                n_state        = S_OUT_WAIT;
            end
            S_WALK_RD: begin
                if (i_stat.walk_done) begin
                    o_cmd.out_init = 1'b1;
                    n_state        = S_OUT_RD;
                end else begin
                    n_state = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                o_cmd.walk_step = 1'b1;
                n_state         = S_WALK_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    n_state        = i_stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT_WAIT);

endmodule

FILE: src/gtls_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtls_dp
// Datapath: prefix sums, candidate deque, predecessor store and route stack.
// ----------------------------------------------------------------------------
module gtls_dp
    import gtls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_word             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output t_out_word            o_out_data
);

    // control registers
    logic [CFG_W-1:0]  r_cap;
    logic [CFG_W-1:0]  r_pen;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_p;
    logic              r_end;
    logic              r_infeas;
    logic [POS_W-1:0]  r_head;
    logic [POS_W-1:0]  r_tail;
    logic [POS_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_k;
    logic [POS_W-1:0]  r_cur;

    // payload registers
    logic [DIST_W-1:0]        r_dsum;
    logic [LOAD_W-1:0]        r_qsum;
    logic [LOAD_W-1:0]        r_qprev;
    logic [COST_W-1:0]        r_vlast;
    logic signed [CVAL_W-1:0] r_cand;
    logic [DST_W-1:0]         r_dout;
    t_out_word                r_out;

    // accept-time arithmetic
    logic                     first;
    logic [POS_W-1:0]         p_new;
    logic [DIST_W-1:0]        d_new;
    logic [LOAD_W-1:0]        q_prev;
    logic [COST_W-1:0]        v_prev;
    logic signed [CVAL_W-1:0] cand;

    // memory ports
    t_qent             q_wdata;
    t_qent             q_rdata;
    logic [POS_W-1:0]  tail_m1;
    logic [QADDR_W-1:0] q_raddr;
    logic [POS_W-1:0]  pred_rdata;
    t_stk              stk_wdata;
    t_stk              stk_rdata;
    logic [POS_W-1:0]  stk_ridx;

    logic [LOAD_W-1:0]        qdiff;
    logic signed [SUM_W-1:0]  csum;
    logic [COST_W-1:0]        c_sat;
    logic [POS_W-1:0]         prev;

    // new prefix values and candidate potential for this customer
    always_comb begin
        first  = (r_pos == '0);
        p_new  = r_pos + 1'b1;
        d_new  = first ? '0 : r_dsum + DIST_W'(i_in_data.dist_from_prev);
        q_prev = first ? '0 : r_qsum;
        v_prev = first ? '0 : r_vlast;
        cand   = $signed(CVAL_W'(v_prev)) + $signed(CVAL_W'(i_in_data.dist_from_depot))
               - $signed(CVAL_W'(d_new));
    end

    // route cost through the head candidate, saturated
    always_comb begin
        qdiff = r_qsum - q_rdata.load;
        csum  = $signed(SUM_W'($signed(q_rdata.val))) + $signed(SUM_W'(r_dsum))
              + $signed(SUM_W'(r_dout)) + $signed(SUM_W'(r_pen));
        c_sat = (csum[SUM_W-1:COST_W] != '0) ? COST_MAX : csum[COST_W-1:0];
    end

    // predecessor of the route ending at the walk cursor
    always_comb begin
        prev = (pred_rdata >= r_cur) ? r_cur - 1'b1 : pred_rdata;
    end

    assign tail_m1  = r_tail - 1'b1;
    assign q_raddr  = i_cmd.q_rd_back ? tail_m1[QADDR_W-1:0] : r_head[QADDR_W-1:0];
    assign q_wdata  = '{idx: r_p - 1'b1, load: r_qprev, val: r_cand};
    assign stk_wdata = '{first: prev + 1'b1, last: r_cur};
    assign stk_ridx = r_cnt - 1'b1 - r_k;

    // candidate deque
    gtls_ram #(.WIDTH($bits(t_qent)), .DEPTH(MAX_TOUR)) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail[QADDR_W-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // best predecessor per position
    gtls_ram #(.WIDTH(POS_W), .DEPTH(MAX_TOUR + 1)) u_pred (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_p),
        .i_wdata (q_rdata.idx),
        .i_raddr (r_cur),
        .o_rdata (pred_rdata)
    );

    // routes in reverse order, read back forward
    gtls_ram #(.WIDTH($bits(t_stk)), .DEPTH(MAX_TOUR)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.walk_step),
        .i_waddr (r_cnt[QADDR_W-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (stk_ridx[QADDR_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= '0;
            r_pen    <= '0;
            r_pos    <= '0;
            r_p      <= '0;
            r_end    <= 1'b0;
            r_infeas <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
            r_cur    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_CAPACITY) begin
                r_cap <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_PENALTY) begin
                r_pen <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_p   <= p_new;
                r_end <= i_in_data.last_customer || (p_new == POS_W'(MAX_TOUR));
                r_pos <= (i_in_data.last_customer || (p_new == POS_W'(MAX_TOUR)))
                         ? '0 : p_new;
                if (first) begin
                    r_infeas <= 1'b0;
                    r_head   <= '0;
                    r_tail   <= '0;
                end
            end
            if (i_cmd.tail_dec) begin
                r_tail <= tail_m1;
            end
            if (i_cmd.push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.head_inc) begin
                r_head <= r_head + 1'b1;
            end
            if (i_cmd.set_infeas) begin
                r_infeas <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_cur <= r_p;
                r_cnt <= '0;
            end
            if (i_cmd.walk_step) begin
                r_cur <= prev;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_init) begin
                r_k <= '0;
            end
            if (i_cmd.out_next) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dsum  <= d_new;
            r_qsum  <= q_prev + LOAD_W'(i_in_data.demand);
            r_qprev <= q_prev;
            r_cand  <= cand;
            r_dout  <= i_in_data.dist_to_depot;
            if (first) begin
                r_vlast <= '0;
            end
        end
        if (i_cmd.commit) begin
            r_vlast <= c_sat;
        end
        if (i_cmd.load_inf) begin
            r_out <= '{feasible: 1'b0, route_number: '0, first_position: '0,
                       last_position: '0, split_cost: COST_MAX, last_route: 1'b1};
        end
        if (i_cmd.load_out) begin
            r_out <= '{feasible: 1'b1, route_number: RN_W'(r_k),
                       first_position: FP_W'(stk_rdata.first),
                       last_position: FP_W'(stk_rdata.last),
                       split_cost: r_vlast, last_route: (r_k + 1'b1 == r_cnt)};
        end
    end

    // status
    assign o_stat.infeas    = r_infeas;
    assign o_stat.q_ne      = (r_tail > r_head);
    assign o_stat.back_pop  = (r_cand <= $signed(q_rdata.val));
    assign o_stat.front_pop = (32'(qdiff) > 32'(r_cap));
    assign o_stat.tour_end  = r_end;
    assign o_stat.walk_done = (r_cur == '0) || (r_cnt == POS_W'(MAX_TOUR));
    assign o_stat.out_last  = r_out.last_route;

    assign o_out_data = r_out;

endmodule

FILE: src/giant_tour_linear_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// giant_tour_linear_split
// Splits a giant tour into capacity-feasible routes at minimum cost.
// ----------------------------------------------------------------------------
//  channel | signals                          | word
//  --------+----------------------------------+---------------------------
//  in      | i_in_valid / o_in_ready          | one customer of the tour
//  out     | o_out_valid / i_out_ready        | one route, or infeasible
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | capacity, route penalty
//
// Each customer runs the deque update: pops at the back, push, pops at the
// front and commit, every deque entry read through the single read port of
// the deque RAM; once the tour is infeasible the update is skipped.
// At tour end the predecessor walk pushes the routes onto a stack, then each
// route word is read back, loaded and held until the output takes it.
// One word at a time: input is not taken while results are pending.
// Synchronous active-low reset; no clearing pass is needed.
module giant_tour_linear_split
    import gtls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    gtls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gtls_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

`ifndef ASSERT_OFF
    // never take a customer while a result word waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while output pending");

    // after the final route word the block is ready again
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_route) |=> o_in_ready)
        else $error("not ready after final route");

    // infeasible word is alone and carries saturated cost
    a_infeasible_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.feasible) |->
        (o_out_data.last_route && o_out_data.split_cost == COST_MAX))
        else $error("malformed infeasible word");

    // a customer is never accepted in the same cycle as a push, a commit or an output advance
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |-> !(cmd.commit || cmd.push || cmd.out_next))
        else $error("conflicting commands");
`endif

endmodule
